// ===== rtl/wfs_pkg.sv =====
// ---------------------------------------------------------------------------
// wfs_pkg
// Shared types and constants of the winnowing fingerprint select unit.
// ---------------------------------------------------------------------------
package wfs_pkg;

  localparam int MAX_GRAM_DEF   = 16;
  localparam int MAX_WINDOW_DEF = 16;

  localparam int HASH_W  = 64;
  localparam int POS_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int BASE_W  = 16;
  localparam int LEN_W   = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // space character, subtracted from each byte before hashing
  localparam logic [HASH_W-1:0] BYTE_OFFSET = 64'd32;

  localparam logic [LEN_W-1:0]  GRAM_LENGTH_RST = 5'd3;
  localparam logic [LEN_W-1:0]  WINDOW_LEN_RST  = 5'd5;
  localparam logic [BASE_W-1:0] HASH_BASE_RST   = 16'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAM_LENGTH = 2'd0,
    REG_WINDOW_LEN  = 2'd1,
    REG_HASH_BASE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_PUSH,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic step;
    logic first;
  } horner_ctrl_t;

endpackage

// ===== rtl/wfs_shift_store.sv =====
// ---------------------------------------------------------------------------
// wfs_shift_store
// Shift line of entries, newest at the top, with one indexed read port.
// ---------------------------------------------------------------------------
module wfs_shift_store #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [WIDTH-1:0] din,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] entries [DEPTH];

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        entries[k] <= entries[k+1];
      end
      entries[DEPTH-1] <= din;
    end
  end

  assign rd_data = entries[rd_addr];

endmodule

// ===== rtl/wfs_horner.sv =====
// ---------------------------------------------------------------------------
// wfs_horner
// Shared multiply-add unit: one Horner step of the gram hash per cycle while step is set.
// ---------------------------------------------------------------------------
module wfs_horner (
  input  logic                             clk,
  input  wfs_pkg::horner_ctrl_t            ctrl,
  input  logic [wfs_pkg::BASE_W-1:0]       base,
  input  logic [wfs_pkg::BYTE_W-1:0]       byte_in,
  output logic [wfs_pkg::HASH_W-1:0]       acc
);

  logic [wfs_pkg::HASH_W-1:0] acc_src;
  logic [wfs_pkg::HASH_W-1:0] prod;
  logic [wfs_pkg::HASH_W-1:0] acc_next;

  always_comb begin
    acc_src  = ctrl.first ? '0 : acc;
    prod     = acc_src * wfs_pkg::HASH_W'(base);
    acc_next = prod + wfs_pkg::HASH_W'(byte_in) - wfs_pkg::BYTE_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      acc <= acc_next;
    end
  end

endmodule

// ===== rtl/winnowing_fingerprint_select_unit.sv =====
// ---------------------------------------------------------------------------
// winnowing_fingerprint_select_unit
// Winnowing selection of gram hashes over a stream of text bytes.
// ---------------------------------------------------------------------------
// One byte item is taken at a time. A byte that completes no gram needs no
// further step. Otherwise the gram hash is built by one multiply-add per byte
// on a single Horner unit, pushed into the window, and when the window is full
// its entries are scanned one per cycle through a single signed compare, then
// a decide step waits while an earlier fingerprint is still held. The next
// byte is taken while a produced fingerprint still waits on the output.
module winnowing_fingerprint_select_unit #(
  parameter int MAX_GRAM   = wfs_pkg::MAX_GRAM_DEF,
  parameter int MAX_WINDOW = wfs_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wfs_pkg::BYTE_W-1:0]          text_byte,
  input  logic                                start_of_text,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wfs_pkg::HASH_W-1:0]   fingerprint,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wfs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int GA_W = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
  localparam int GC_W = $clog2(MAX_GRAM + 1);
  localparam int WA_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WC_W = $clog2(MAX_WINDOW + 1);
  localparam int ENT_W = wfs_pkg::HASH_W + wfs_pkg::POS_W;

  // configuration
  logic [wfs_pkg::LEN_W-1:0]  gram_length;
  logic [wfs_pkg::LEN_W-1:0]  window_len;
  logic [wfs_pkg::BASE_W-1:0] hash_base;

  // control state
  wfs_pkg::state_t            state, state_next;
  logic [wfs_pkg::POS_W-1:0]  bytes_seen, bytes_seen_next;
  logic [wfs_pkg::POS_W-1:0]  hashes_seen;
  logic [WC_W-1:0]            window_fill, window_fill_next;
  logic [wfs_pkg::POS_W-1:0]  last_pick_position;
  logic                       pick_valid;
  logic [GC_W-1:0]            step_cnt;
  logic [WC_W-1:0]            scan_cnt;

  // payload
  logic signed [wfs_pkg::HASH_W-1:0] best_hash;
  logic [wfs_pkg::POS_W-1:0]         best_pos;

  logic [GC_W-1:0] g_eff;
  logic [WC_W-1:0] w_eff;
  logic            accept;
  logic            byte_shift;
  logic            win_shift;
  logic            emit;
  logic            hash_last;
  logic            scan_last;
  logic            repeat_pick;

  wfs_pkg::horner_ctrl_t          hctrl;
  logic [wfs_pkg::BYTE_W-1:0]     rd_byte;
  logic [GA_W-1:0]                byte_addr;
  logic [wfs_pkg::HASH_W-1:0]     gram_hash;
  logic [WA_W-1:0]                win_addr;
  logic [WC_W-1:0]                win_idx;
  logic [ENT_W-1:0]               win_rd;
  logic signed [wfs_pkg::HASH_W-1:0] rd_hash;
  logic [wfs_pkg::POS_W-1:0]      rd_pos;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gram_length <= wfs_pkg::GRAM_LENGTH_RST;
      window_len  <= wfs_pkg::WINDOW_LEN_RST;
      hash_base   <= wfs_pkg::HASH_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wfs_pkg::REG_GRAM_LENGTH: gram_length <= cfg_data[wfs_pkg::LEN_W-1:0];
        wfs_pkg::REG_WINDOW_LEN:  window_len  <= cfg_data[wfs_pkg::LEN_W-1:0];
        wfs_pkg::REG_HASH_BASE:   hash_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (gram_length == '0) begin
      g_eff = GC_W'(1);
    end else if (32'(gram_length) > 32'(MAX_GRAM)) begin
      g_eff = GC_W'(MAX_GRAM);
    end else begin
      g_eff = GC_W'(gram_length);
    end
    if (window_len == '0) begin
      w_eff = WC_W'(1);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      w_eff = WC_W'(MAX_WINDOW);
    end else begin
      w_eff = WC_W'(window_len);
    end
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    if (start_of_text) begin
      bytes_seen_next = wfs_pkg::POS_W'(1);
    end else if (bytes_seen != '1) begin
      bytes_seen_next = bytes_seen + wfs_pkg::POS_W'(1);
    end else begin
      bytes_seen_next = bytes_seen;
    end
    if (window_fill == WC_W'(MAX_WINDOW)) begin
      window_fill_next = window_fill;
    end else begin
      window_fill_next = window_fill + WC_W'(1);
    end
  end

  assign hash_last   = (step_cnt == g_eff - GC_W'(1));
  assign scan_last   = (scan_cnt == w_eff - WC_W'(1));
  assign repeat_pick = pick_valid && (best_pos == last_pick_position);

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      wfs_pkg::ST_IDLE: begin
        if (accept && (bytes_seen_next >= wfs_pkg::POS_W'(g_eff))) begin
          state_next = wfs_pkg::ST_HASH;
        end
      end
      wfs_pkg::ST_HASH: begin
        if (hash_last) begin
          state_next = wfs_pkg::ST_PUSH;
        end
      end
      wfs_pkg::ST_PUSH: begin
        if (window_fill_next < w_eff) begin
          state_next = wfs_pkg::ST_IDLE;
        end else begin
          state_next = wfs_pkg::ST_SCAN;
        end
      end
      wfs_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = wfs_pkg::ST_DECIDE;
        end
      end
      wfs_pkg::ST_DECIDE: begin
        if (repeat_pick || !(out_valid && out_stall)) begin
          state_next = wfs_pkg::ST_IDLE;
        end
      end
      default: state_next = wfs_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall    = 1'b1;
    byte_shift  = 1'b0;
    win_shift   = 1'b0;
    emit        = 1'b0;
    hctrl.step  = 1'b0;
    hctrl.first = 1'b0;
    unique case (state)
      wfs_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        byte_shift = accept;
      end
      wfs_pkg::ST_HASH: begin
        hctrl.step  = 1'b1;
        hctrl.first = (step_cnt == '0);
      end
      wfs_pkg::ST_PUSH: begin
        win_shift = 1'b1;
      end
      wfs_pkg::ST_SCAN: ;
      wfs_pkg::ST_DECIDE: begin
        emit = !repeat_pick && !(out_valid && out_stall);
      end
      default: ;
    endcase
  end

  assign byte_addr = GA_W'(MAX_GRAM - 1) - step_cnt[GA_W-1:0];
  assign win_idx   = WC_W'(MAX_WINDOW) - w_eff + scan_cnt;
  assign win_addr  = win_idx[WA_W-1:0];
  assign rd_hash   = $signed(win_rd[ENT_W-1:wfs_pkg::POS_W]);
  assign rd_pos    = win_rd[wfs_pkg::POS_W-1:0];

  wfs_shift_store #(
    .WIDTH (wfs_pkg::BYTE_W),
    .DEPTH (MAX_GRAM),
    .AW    (GA_W)
  ) u_bytes (
    .clk      (clk),
    .shift_en (byte_shift),
    .din      (text_byte),
    .rd_addr  (byte_addr),
    .rd_data  (rd_byte)
  );

  wfs_horner u_horner (
    .clk     (clk),
    .ctrl    (hctrl),
    .base    (hash_base),
    .byte_in (rd_byte),
    .acc     (gram_hash)
  );

  wfs_shift_store #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WINDOW),
    .AW    (WA_W)
  ) u_window (
    .clk      (clk),
    .shift_en (win_shift),
    .din      ({gram_hash, hashes_seen}),
    .rd_addr  (win_addr),
    .rd_data  (win_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= wfs_pkg::ST_IDLE;
      bytes_seen         <= '0;
      hashes_seen        <= '0;
      window_fill        <= '0;
      last_pick_position <= '0;
      pick_valid         <= 1'b0;
      step_cnt           <= '0;
      scan_cnt           <= '0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        bytes_seen <= bytes_seen_next;
        step_cnt   <= '0;
        if (start_of_text) begin
          hashes_seen        <= '0;
          window_fill        <= '0;
          last_pick_position <= '0;
          pick_valid         <= 1'b0;
        end
      end
      if (state == wfs_pkg::ST_HASH) begin
        step_cnt <= step_cnt + GC_W'(1);
      end
      if (win_shift) begin
        hashes_seen <= hashes_seen + wfs_pkg::POS_W'(1);
        window_fill <= window_fill_next;
        scan_cnt    <= '0;
      end
      if (state == wfs_pkg::ST_SCAN) begin
        scan_cnt <= scan_cnt + WC_W'(1);
      end
      if (emit) begin
        out_valid          <= 1'b1;
        pick_valid         <= 1'b1;
        last_pick_position <= best_pos;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan compare: strictly smaller replaces, so ties keep the oldest
  always_ff @(posedge clk) begin
    if (state == wfs_pkg::ST_SCAN) begin
      if ((scan_cnt == '0) || (rd_hash < best_hash)) begin
        best_hash <= rd_hash;
        best_pos  <= rd_pos;
      end
    end
    if (emit) begin
      fingerprint <= best_hash;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(window_fill) <= 32'(MAX_WINDOW))
    else $error("window fill above depth");

  a_scan_full: assert property (@(posedge clk) disable iff (rst)
    (state == wfs_pkg::ST_SCAN) |-> (window_fill >= w_eff))
    else $error("scan on a window that is not full");

  a_hash_gram: assert property (@(posedge clk) disable iff (rst)
    (state == wfs_pkg::ST_HASH) |-> (bytes_seen >= wfs_pkg::POS_W'(g_eff)))
    else $error("hash of an incomplete gram");

  a_emit_pick: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && pick_valid && (last_pick_position == $past(best_pos))))
    else $error("result without matching pick");

endmodule
